// ===== hw/rtl/key_protected_watchdog_core_assert.svh =====
// Assertion macros used by the watchdog engine RTL (kwd_engine).
`ifndef KEY_PROTECTED_WATCHDOG_CORE_ASSERT_SVH
`define KEY_PROTECTED_WATCHDOG_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KWD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KWD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KWD_ASSERT(label, clk, rst, prop, msg)
`define KWD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/kwd_pkg.sv =====
// Types and constants of the key-protected watchdog.
`default_nettype none
package kwd_pkg;
   localparam int READ_W   = 12;
   localparam int PRESC_W  = 3;
   localparam int WAIT_W   = 3;
   localparam int DATA_W   = 16;

   localparam logic [DATA_W-1:0] KEY_UNLOCK = 16'h5555;
   localparam logic [DATA_W-1:0] KEY_FEED   = 16'hAAAA;
   localparam logic [DATA_W-1:0] KEY_START  = 16'hCCCC;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      OFF_KEY    = 2'd0,
      OFF_PRESC  = 2'd1,
      OFF_RELOAD = 2'd2,
      OFF_STATUS = 2'd3
   } offset_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [1:0]        reg_offset;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [READ_W-1:0] read_data;
      logic              reset_request;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/kwd_engine.sv =====
// Watchdog register file, prescaler and down-counter with the per-request update logic.
`default_nettype none
`include "key_protected_watchdog_core_assert.svh"
module kwd_engine #(
   parameter int RELOAD_BITS    = 12,
   parameter int PRESCALE_STEPS = 7,
   parameter int UPDATE_TICKS   = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  kwd_pkg::req_type req,
   output kwd_pkg::rsp_type rsp
);
   import kwd_pkg::*;

   localparam int DIV_BITS = PRESCALE_STEPS + 1;
   localparam logic [RELOAD_BITS-1:0] RELOAD_ONES = '1;
   localparam logic [PRESC_W-1:0] STEP_MAX = PRESC_W'(PRESCALE_STEPS - 1);
   localparam logic [WAIT_W-1:0] WAIT_START = WAIT_W'(UPDATE_TICKS);

   logic                   running_ff, running_in;
   logic                   unlocked_ff, unlocked_in;
   logic [PRESC_W-1:0]     presc_wr_ff, presc_wr_in;
   logic [PRESC_W-1:0]     presc_use_ff, presc_use_in;
   logic [RELOAD_BITS-1:0] reload_wr_ff, reload_wr_in;
   logic [RELOAD_BITS-1:0] reload_use_ff, reload_use_in;
   logic [DIV_BITS-1:0]    div_cnt_ff, div_cnt_in;
   logic [RELOAD_BITS-1:0] down_ff, down_in;
   logic [WAIT_W-1:0]      presc_wait_ff, presc_wait_in;
   logic [WAIT_W-1:0]      reload_wait_ff, reload_wait_in;

   logic [PRESC_W-1:0]     step_now;
   logic [DIV_BITS:0]      div_limit;
   logic [DIV_BITS:0]      cnt_plus;
   logic                   expire;
   logic [RELOAD_BITS+READ_W-1:0] reload_ext;

   assign reload_ext = {{READ_W{1'b0}}, reload_wr_ff};
   assign cnt_plus   = {1'b0, div_cnt_ff} + (DIV_BITS+1)'(1);

   always_comb begin
      running_in     = running_ff;
      unlocked_in    = unlocked_ff;
      presc_wr_in    = presc_wr_ff;
      presc_use_in   = presc_use_ff;
      reload_wr_in   = reload_wr_ff;
      reload_use_in  = reload_use_ff;
      div_cnt_in     = div_cnt_ff;
      down_in        = down_ff;
      presc_wait_in  = presc_wait_ff;
      reload_wait_in = reload_wait_ff;
      expire         = 1'b0;
      rsp.read_data  = '0;
      step_now       = '0;
      div_limit      = '0;

      case (req.command)
         CMD_TICK: begin
            if (presc_wait_ff != '0) begin
               presc_wait_in = presc_wait_ff - WAIT_W'(1);
               if (presc_wait_ff == WAIT_W'(1)) begin
                  presc_use_in = presc_wr_ff;
               end
            end
            if (reload_wait_ff != '0) begin
               reload_wait_in = reload_wait_ff - WAIT_W'(1);
               if (reload_wait_ff == WAIT_W'(1)) begin
                  reload_use_in = reload_wr_ff;
               end
            end
            step_now  = (presc_use_in > STEP_MAX) ? STEP_MAX : presc_use_in;
            div_limit = (DIV_BITS+1)'(4) << step_now;
            if (running_ff) begin
               if (cnt_plus >= div_limit) begin
                  div_cnt_in = '0;
                  if (down_ff == '0) begin
                     expire = 1'b1;
                  end else begin
                     down_in = down_ff - RELOAD_BITS'(1);
                  end
               end else begin
                  div_cnt_in = cnt_plus[DIV_BITS-1:0];
               end
            end
         end
         CMD_WRITE: begin
            unique case (req.reg_offset)
               OFF_KEY: begin
                  unlocked_in = (req.write_data == KEY_UNLOCK);
                  if (req.write_data == KEY_FEED) begin
                     down_in = reload_use_ff;
                  end
                  if (req.write_data == KEY_START) begin
                     running_in = 1'b1;
                  end
               end
               OFF_PRESC: begin
                  if (unlocked_ff) begin
                     presc_wr_in   = req.write_data[PRESC_W-1:0];
                     presc_wait_in = WAIT_START;
                  end
               end
               OFF_RELOAD: begin
                  if (unlocked_ff) begin
                     reload_wr_in   = req.write_data[RELOAD_BITS-1:0];
                     reload_wait_in = WAIT_START;
                  end
               end
               default: begin
               end
            endcase
         end
         CMD_READ: begin
            unique case (req.reg_offset)
               OFF_PRESC:  rsp.read_data = READ_W'(presc_wr_ff);
               OFF_RELOAD: rsp.read_data = reload_ext[READ_W-1:0];
               OFF_STATUS: rsp.read_data = {{(READ_W-2){1'b0}},
                                            reload_wait_ff != '0,
                                            presc_wait_ff != '0};
               default:    rsp.read_data = '0;
            endcase
         end
         default: begin
         end
      endcase

      if (expire) begin
         running_in     = 1'b0;
         unlocked_in    = 1'b0;
         presc_wr_in    = '0;
         presc_use_in   = '0;
         reload_wr_in   = RELOAD_ONES;
         reload_use_in  = RELOAD_ONES;
         div_cnt_in     = '0;
         down_in        = RELOAD_ONES;
         presc_wait_in  = '0;
         reload_wait_in = '0;
      end
      rsp.reset_request = expire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff     <= 1'b0;
         unlocked_ff    <= 1'b0;
         presc_wr_ff    <= '0;
         presc_use_ff   <= '0;
         reload_wr_ff   <= RELOAD_ONES;
         reload_use_ff  <= RELOAD_ONES;
         div_cnt_ff     <= '0;
         down_ff        <= RELOAD_ONES;
         presc_wait_ff  <= '0;
         reload_wait_ff <= '0;
      end else if (fire) begin
         running_ff     <= running_in;
         unlocked_ff    <= unlocked_in;
         presc_wr_ff    <= presc_wr_in;
         presc_use_ff   <= presc_use_in;
         reload_wr_ff   <= reload_wr_in;
         reload_use_ff  <= reload_use_in;
         div_cnt_ff     <= div_cnt_in;
         down_ff        <= down_in;
         presc_wait_ff  <= presc_wait_in;
         reload_wait_ff <= reload_wait_in;
      end
   end

   `KWD_ASSERT(a_expire_clears, clock, reset, fire && rsp.reset_request |=> !running_ff && down_ff == RELOAD_ONES, "expiry did not return the watchdog to reset")
   `KWD_ASSERT(a_expire_on_tick, clock, reset, fire && rsp.reset_request |-> running_ff && req.command == CMD_TICK, "reset request without a running tick")
   `KWD_ASSERT(a_idle_holds, clock, reset, !fire |=> $stable(down_ff) && $stable(running_ff), "counter moved without a request")
   `KWD_ASSERT(a_wait_bound, clock, reset, presc_wait_ff <= WAIT_START && reload_wait_ff <= WAIT_START, "update wait beyond its start value")
endmodule
`default_nettype wire

// ===== hw/rtl/key_protected_watchdog_core.sv =====
// Top level of the key-protected watchdog: request and response registers around the engine.
//
// Each request is a slow-clock tick, a register write or a register read, and
// each request gives exactly one response carrying read_data and reset_request.
// The request channel (req_valid, req_stall, req_item) feeds an input register;
// the engine updates the watchdog state as the request moves into the response
// register (rsp_valid, rsp_stall, rsp_item).
// A request is taken into the input register and then moves on into the response
// register, where it becomes valid and can be taken; one request is accepted every
// cycle while the response side keeps up.
// When the receiver stalls, the response register holds its value and the
// input register holds one more request; after that req_stall rises.
// A synchronous reset empties both registers and puts every watchdog register
// back to its reset value: stopped, locked, prescaler 0, reload all ones.
// A counter expiry gives a response with reset_request set and performs the
// same return to reset values inside the block.
`default_nettype none
module key_protected_watchdog_core #(
   parameter int RELOAD_BITS    = 12,
   parameter int PRESCALE_STEPS = 7,
   parameter int UPDATE_TICKS   = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kwd_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output kwd_pkg::rsp_type rsp_item
);
   import kwd_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_item_ff, rsp_item_in;
   rsp_type eng_rsp;
   logic    advance;
   logic    accept;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      in_item_in   = accept ? req_item : in_item_ff;
      rsp_valid_in = advance ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_item_in  = advance ? eng_rsp : rsp_item_ff;
   end

   kwd_engine #(
      .RELOAD_BITS   (RELOAD_BITS),
      .PRESCALE_STEPS(PRESCALE_STEPS),
      .UPDATE_TICKS  (UPDATE_TICKS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .fire (advance),
      .req  (in_item_ff),
      .rsp  (eng_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;
endmodule
`default_nettype wire
